FILE: rtl/tcgr_pkg.sv
// Shared types, constants and a helper function of the text cell glyph renderer.
`default_nettype none

package tcgr_pkg;

	localparam int FONT_ADDR_W        = 12;
	localparam int FONT_DEPTH         = 4096;
	localparam int FONT_DATA_W        = 8;
	localparam int GLYPH_WIDTH        = 8;
	localparam int COLOR_W            = 4;
	localparam int ROW_PIXELS_W       = GLYPH_WIDTH * COLOR_W;
	localparam int GLYPH_ROW_W        = 4;
	localparam int MAX_ROWS           = 16;
	localparam int DEF_GLYPH_HEIGHT   = 16;

	// Request kinds.
	localparam logic KIND_FONT_WRITE = 1'b0;
	localparam logic KIND_RENDER     = 1'b1;

	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic                   kind;
		logic [FONT_ADDR_W-1:0] font_address;
		logic [FONT_DATA_W-1:0] font_byte;
		logic [7:0]             char_code;
		logic [7:0]             attribute;
		logic                   blink_phase;
	} req_t;

	typedef struct packed {
		logic [GLYPH_ROW_W-1:0]  glyph_row;
		logic [ROW_PIXELS_W-1:0] row_pixels;
		logic                    last_row;
	} rsp_t;

	// Font bit p selects foreground or background for pixel p (pixel 0 leftmost).
	function automatic logic [ROW_PIXELS_W-1:0] build_row(
		input logic [FONT_DATA_W-1:0] bits,
		input color_t                 fg,
		input color_t                 bg
	);
		logic [ROW_PIXELS_W-1:0] word;
		word = '0;
		for (int p = 0; p < GLYPH_WIDTH; p++) begin
			word[p*COLOR_W +: COLOR_W] = bits[p] ? fg : bg;
		end
		return word;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/text_cell_glyph_renderer_core.sv
// Top level of the text cell glyph renderer: font memory, row sequencer, output register.
//
//   channel   signals                  direction  handshake
//   request   start, busy, req         in         taken when start & !busy
//   result    row_valid, rsp           out        one row per cycle within a cell, no back-pressure
//
// A font write leaves busy low.
// A render holds busy after its request cycle until each of its min(GLYPH_HEIGHT, 16) rows
// has been read, one font memory read per row, so a new request waits until the render ends;
// the single memory port sets this.
// Rows leave through the registered memory read and the output register; a new request may enter while they drain.
// Reset clears control state only; font memory contents are undefined until written.
`default_nettype none

module text_cell_glyph_renderer_core #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire tcgr_pkg::req_t req,
	output logic               row_valid,
	output tcgr_pkg::rsp_t     rsp
);

	import tcgr_pkg::*;

	localparam int ROWS = (GLYPH_HEIGHT < MAX_ROWS) ? GLYPH_HEIGHT : MAX_ROWS;
	localparam logic [GLYPH_ROW_W-1:0] LAST_ROW = GLYPH_ROW_W'(ROWS - 1);
	localparam logic [FONT_ADDR_W-1:0] HEIGHT_A = FONT_ADDR_W'(GLYPH_HEIGHT);

	typedef enum logic {
		ST_IDLE,
		ST_RENDER
	} state_t;

	state_t                 state_q;
	logic [GLYPH_ROW_W-1:0] row_q;
	logic [FONT_ADDR_W-1:0] base_q;
	color_t                 fg_q;
	color_t                 bg_q;

	logic                   valid_s1;
	logic [GLYPH_ROW_W-1:0] row_s1;
	logic                   last_s1;
	color_t                 fg_s1;
	color_t                 bg_s1;

	logic                   accept;
	logic                   font_we;
	logic [FONT_ADDR_W-1:0] font_addr;
	logic [FONT_DATA_W-1:0] font_rdata;
	logic [FONT_ADDR_W-1:0] cell_base;
	color_t                 fg_new;
	color_t                 bg_new;

	assign accept  = start && (state_q == ST_IDLE);
	assign font_we = accept && (req.kind == KIND_FONT_WRITE);
	assign busy    = (state_q == ST_RENDER);

	assign cell_base = FONT_ADDR_W'({{(FONT_ADDR_W-8){1'b0}}, req.char_code} * HEIGHT_A);
	assign font_addr = busy ? (base_q + FONT_ADDR_W'(row_q)) : req.font_address;

	// A blinking cell drops the blink bit from the background, and in the dark
	// half-period the foreground is painted in the background colour.
	always_comb begin
		fg_new = req.attribute[3:0];
		bg_new = req.attribute[7:4];
		if (bg_new[3]) begin
			bg_new = {1'b0, bg_new[2:0]};
			if (!req.blink_phase) begin
				fg_new = bg_new;
			end
		end
	end

	tcgr_ram #(
		.WIDTH(FONT_DATA_W),
		.DEPTH(FONT_DEPTH)
	) u_font_ram (
		.clk  (clk),
		.we   (font_we),
		.addr (font_addr),
		.wdata(req.font_byte),
		.rdata(font_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					row_q <= '0;
					if (accept && (req.kind == KIND_RENDER)) begin
						state_q <= ST_RENDER;
					end
				end
				ST_RENDER: begin
					row_q <= row_q + 1'b1;
					if (row_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.kind == KIND_RENDER)) begin
			base_q <= cell_base;
			fg_q   <= fg_new;
			bg_q   <= bg_new;
		end
	end

	// Stage 1 lines up with the registered font memory read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			row_valid <= 1'b0;
		end else begin
			valid_s1  <= busy;
			row_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= row_q;
		last_s1 <= (row_q == LAST_ROW);
		fg_s1   <= fg_q;
		bg_s1   <= bg_q;
		rsp.glyph_row  <= row_s1;
		rsp.row_pixels <= build_row(font_rdata, fg_s1, bg_s1);
		rsp.last_row   <= last_s1;
	end

endmodule

`default_nettype wire

FILE: rtl/tcgr_ram.sv
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module tcgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

FILE: rtl/tcgr_checker.sv
// Port-level checks of the text cell glyph renderer and their bind to the top level.
`default_nettype none

module tcgr_checker #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT
) (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           start,
	input wire logic           busy,
	input wire tcgr_pkg::req_t req,
	input wire logic           row_valid,
	input wire tcgr_pkg::rsp_t rsp
);

	import tcgr_pkg::*;

	localparam int ROWS = (GLYPH_HEIGHT < MAX_ROWS) ? GLYPH_HEIGHT : MAX_ROWS;
	localparam logic [GLYPH_ROW_W-1:0] LAST_ROW = GLYPH_ROW_W'(ROWS - 1);

	// Rows of one cell come out on consecutive cycles with no gap.
	a_rows_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !rsp.last_row |=> row_valid)
		else $error("row stream of a cell has a gap");

	a_row_increments: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !rsp.last_row |=>
			rsp.glyph_row == $past(rsp.glyph_row) + 1'b1)
		else $error("glyph row index did not advance by one");

	a_last_row_index: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && rsp.last_row |-> rsp.glyph_row == LAST_ROW)
		else $error("last row flag on the wrong row");

	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind == KIND_RENDER |=> busy)
		else $error("render request did not raise busy");

	a_write_no_rows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.kind == KIND_FONT_WRITE |=> !busy)
		else $error("font write request raised busy");

endmodule

bind text_cell_glyph_renderer_core tcgr_checker #(
	.GLYPH_HEIGHT(GLYPH_HEIGHT)
) u_tcgr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.req      (req),
	.row_valid(row_valid),
	.rsp      (rsp)
);

`default_nettype wire

FILE: dv/text_cell_glyph_renderer_checker.sv
// Row checker: watches requests and rows of the glyph renderer, predicts and compares each row.
module text_cell_glyph_renderer_checker #(
	parameter int GLYPH_HEIGHT = tcgr_pkg::DEF_GLYPH_HEIGHT
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic           busy,
	input  wire tcgr_pkg::req_t req,
	input  wire logic           row_valid,
	input  wire tcgr_pkg::rsp_t rsp,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tcgr_pkg::*;

	localparam int CELL_ROWS = (GLYPH_HEIGHT < MAX_ROWS) ? GLYPH_HEIGHT : MAX_ROWS;

	logic [FONT_DATA_W-1:0] font_copy [FONT_DEPTH];
	rsp_t                   rows_due [$];
	int                     fail_count = 0;
	int                     rows_left  = 0;

	assign errors  = fail_count;
	assign pending = rows_left;

	task automatic report_mismatch(input string what);
		$display("%t row checker: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic logic [ROW_PIXELS_W-1:0] paint_row(
		input logic [FONT_DATA_W-1:0] bits,
		input logic [COLOR_W-1:0]     on_color,
		input logic [COLOR_W-1:0]     off_color
	);
		logic [ROW_PIXELS_W-1:0] word;
		word = '0;
		for (int p = 0; p < GLYPH_WIDTH; p++) begin
			word[COLOR_W*p +: COLOR_W] = bits[p] ? on_color : off_color;
		end
		return word;
	endfunction

	task automatic render_cell(input logic [7:0] code, input logic [7:0] attr, input logic phase);
		logic [COLOR_W-1:0]     fg;
		logic [COLOR_W-1:0]     bg;
		logic [FONT_ADDR_W-1:0] addr;
		int                     flat;
		rsp_t                   row;
		fg = attr[3:0];
		bg = attr[7:4];
		// A blinking background loses its bright bit; in the dark phase the glyph vanishes.
		if (bg[3]) begin
			bg[3] = 1'b0;
			if (!phase) begin
				fg = bg;
			end
		end
		for (int r = 0; r < CELL_ROWS; r++) begin
			flat = int'(code) * GLYPH_HEIGHT + r;
			addr = flat[FONT_ADDR_W-1:0];
			row.glyph_row  = r[GLYPH_ROW_W-1:0];
			row.row_pixels = paint_row(font_copy[addr], fg, bg);
			row.last_row   = (r == CELL_ROWS - 1);
			rows_due.push_back(row);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (row_valid) begin
				if (rows_due.size() == 0) begin
					report_mismatch($sformatf("unexpected row %0d", rsp.glyph_row));
				end else begin
					want = rows_due.pop_front();
					if (rsp.glyph_row !== want.glyph_row) begin
						report_mismatch($sformatf("glyph_row %0d, expected %0d",
							rsp.glyph_row, want.glyph_row));
					end
					if (rsp.row_pixels !== want.row_pixels) begin
						report_mismatch($sformatf("row %0d row_pixels %h, expected %h",
							want.glyph_row, rsp.row_pixels, want.row_pixels));
					end
					if (rsp.last_row !== want.last_row) begin
						report_mismatch($sformatf("row %0d last_row %b, expected %b",
							want.glyph_row, rsp.last_row, want.last_row));
					end
				end
			end
			if (start && !busy) begin
				if (req.kind == KIND_FONT_WRITE) begin
					font_copy[req.font_address] = req.font_byte;
				end else begin
					render_cell(req.char_code, req.attribute, req.blink_phase);
				end
			end
			rows_left <= rows_due.size();
		end
	end

endmodule

FILE: dv/tb_text_cell_glyph_renderer_core.sv
// Testbench top: clock, reset and request stimulus for the glyph renderer, plus the verdict.
module tb_text_cell_glyph_renderer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tcgr_pkg::*;

	localparam int HEIGHT      = DEF_GLYPH_HEIGHT;
	localparam int ITEM_TARGET = 110;
	localparam int CYCLE_LIMIT = 100000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	req_t req = '0;
	logic row_valid;
	rsp_t rsp;
	int   errors;
	int   pending;
	int   cycles = 0;
	int   issued = 0;
	int   burst_left = 0;
	logic [7:0] done_codes [$];

	always #5 clk = ~clk;

	text_cell_glyph_renderer_core #(.GLYPH_HEIGHT(HEIGHT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.row_valid(row_valid),
		.rsp(rsp)
	);

	text_cell_glyph_renderer_checker #(.GLYPH_HEIGHT(HEIGHT)) row_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.row_valid(row_valid),
		.rsp(rsp),
		.errors(errors),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("** text_cell_glyph_renderer_core: FAILED **");
			$finish;
		end
	end

	// Holds the request until it is taken, then either keeps the burst going or idles.
	task automatic issue(input req_t r);
		logic [63:0] junk;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		issued++;
		if (burst_left == 0) begin
			junk = {$urandom(), $urandom()};
			start <= 1'b0;
			req   <= junk[$bits(req_t)-1:0];
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		end else begin
			burst_left--;
		end
	endtask

	function automatic req_t font_write(input int addr, input logic [7:0] bits);
		req_t r;
		r.kind         = KIND_FONT_WRITE;
		r.font_address = addr[FONT_ADDR_W-1:0];
		r.font_byte    = bits;
		r.char_code    = 8'($urandom());
		r.attribute    = 8'($urandom());
		r.blink_phase  = 1'($urandom());
		return r;
	endfunction

	function automatic req_t render(input logic [7:0] code, input logic [7:0] attr, input logic phase);
		req_t r;
		r.kind         = KIND_RENDER;
		r.font_address = 12'($urandom());
		r.font_byte    = 8'($urandom());
		r.char_code    = code;
		r.attribute    = attr;
		r.blink_phase  = phase;
		return r;
	endfunction

	task automatic load_glyph(input logic [7:0] code);
		for (int r = 0; r < HEIGHT; r++) begin
			issue(font_write(int'(code) * HEIGHT + r, 8'($urandom())));
		end
		done_codes.push_back(code);
	endtask

	initial begin
		logic [7:0] row_patterns [8];
		logic [7:0] code;
		row_patterns = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h0F, 8'hF0};
		code = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Glyph 0 gets the extreme row patterns, then is drawn with plain, bright and
		// blinking attributes in both blink phases.
		for (int r = 0; r < HEIGHT; r++) begin
			issue(font_write(r, (r < 8) ? row_patterns[r] : 8'($urandom())));
		end
		done_codes.push_back(8'h00);
		issue(render(8'h00, 8'h00, 1'b0));
		issue(render(8'h00, 8'hFF, 1'b0));
		issue(render(8'h00, 8'hFF, 1'b1));
		issue(render(8'h00, 8'h7A, 1'b0));
		issue(render(8'h00, 8'h9C, 1'b1));
		issue(render(8'h00, 8'h8E, 1'b0));

		// Each round loads a glyph and draws known glyphs; codes come in complementary
		// pairs so that every code bit is seen both ways.
		for (int round = 0; issued < ITEM_TARGET; round++) begin
			code = (round % 2 == 0) ? 8'($urandom()) : ~code;
			load_glyph(code);
			repeat ($urandom_range(0, 3)) begin
				issue(font_write($urandom_range(0, FONT_DEPTH - 1), 8'($urandom())));
			end
			repeat ($urandom_range(2, 4)) begin
				issue(render(done_codes[$urandom_range(0, done_codes.size() - 1)],
					8'($urandom()), 1'($urandom())));
			end
		end

		if (start) begin
			start <= 1'b0;
		end
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("** text_cell_glyph_renderer_core: PASSED **");
		end else begin
			$display("** text_cell_glyph_renderer_core: FAILED **");
		end
		$finish;
	end

endmodule
